// ===== rtl/first_fit_block_allocator_unit_defines.svh =====
// Assertion macros used by the allocator checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
package ffba_pkg;

  localparam int POOL_BYTES = 4096;
  localparam int WORDS      = POOL_BYTES / 4;
  localparam int ADDR_W     = $clog2(WORDS);
  localparam int LEN_W      = 13;
  localparam int OFF_W      = 12;
  localparam int POS_W      = (LEN_W + 1 > ADDR_W + 2) ? LEN_W + 1 : ADDR_W + 2;
  localparam int HDR_BYTES  = 4;
  localparam int POOL_LIM   = (POOL_BYTES / 4) * 4;
  localparam int POOL_CAP   = (POOL_LIM > 8188) ? 8188 : POOL_LIM;

  localparam logic [LEN_W-1:0] POOL_MAX   = LEN_W'(POOL_CAP);
  localparam logic [LEN_W-1:0] POOL_MIN   = LEN_W'(8);
  localparam logic [LEN_W-1:0] POOL_RESET = LEN_W'((POOL_LIM < 4096) ? POOL_LIM : 4096);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } hdr_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hdr_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_LOAD,
    OP_RD_POS,
    OP_RD_HP,
    OP_TAKE_SPLIT,
    OP_TAKE_HEAD,
    OP_ADV,
    OP_FAIL,
    OP_DONE,
    OP_P_LATCH,
    OP_MERGE_N,
    OP_WR_P,
    OP_WR_PREV
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOACC,
    C_REL,
    C_REQ_BIG,
    C_POS_END,
    C_LEN_ZERO,
    C_NOFIT,
    C_OUT_BUSY,
    C_BAD_REL,
    C_NO_NEXT,
    C_ENDS_AT_HP,
    C_WALK_END
  } cond_e;

  localparam int STEP_W = 5;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic noacc;
    logic is_rel;
    logic req_big;
    logic pos_end;
    logic len_zero;
    logic nofit;
    logic out_busy;
    logic bad_rel;
    logic no_next;
    logic ends_at_hp;
    logic walk_end;
  } flags_t;

  // Program step addresses.
  localparam logic [STEP_W-1:0] S_WAIT    = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_LOAD    = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_A_CHK   = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_A_RD    = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_A_EVAL  = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_A_FIT   = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_A_SPLIT = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_A_HEAD  = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_A_ADV   = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_A_FAIL  = STEP_W'(9);
  localparam logic [STEP_W-1:0] S_DONE    = STEP_W'(10);
  localparam logic [STEP_W-1:0] S_END     = STEP_W'(11);
  localparam logic [STEP_W-1:0] S_R_CHK   = STEP_W'(12);
  localparam logic [STEP_W-1:0] S_R_RDP   = STEP_W'(13);
  localparam logic [STEP_W-1:0] S_R_PLAT  = STEP_W'(14);
  localparam logic [STEP_W-1:0] S_R_RDN   = STEP_W'(15);
  localparam logic [STEP_W-1:0] S_R_MRG   = STEP_W'(16);
  localparam logic [STEP_W-1:0] S_R_WRP   = STEP_W'(17);
  localparam logic [STEP_W-1:0] S_R_RDQ   = STEP_W'(18);
  localparam logic [STEP_W-1:0] S_R_ZERO  = STEP_W'(19);
  localparam logic [STEP_W-1:0] S_R_HIT   = STEP_W'(20);
  localparam logic [STEP_W-1:0] S_R_LAST  = STEP_W'(21);
  localparam logic [STEP_W-1:0] S_R_ADV   = STEP_W'(22);
  localparam logic [STEP_W-1:0] S_R_PREV  = STEP_W'(23);

  // Control store: one word per step; jump to target when cond holds, else step on.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
    case (step)
      S_WAIT:    w = '{op: OP_WAIT,       cond: C_NOACC,      target: S_WAIT};
      S_LOAD:    w = '{op: OP_LOAD,       cond: C_REL,        target: S_R_CHK};
      S_A_CHK:   w = '{op: OP_NOP,        cond: C_REQ_BIG,    target: S_A_FAIL};
      S_A_RD:    w = '{op: OP_RD_POS,     cond: C_POS_END,    target: S_A_FAIL};
      S_A_EVAL:  w = '{op: OP_NOP,        cond: C_LEN_ZERO,   target: S_A_FAIL};
      S_A_FIT:   w = '{op: OP_NOP,        cond: C_NOFIT,      target: S_A_ADV};
      S_A_SPLIT: w = '{op: OP_TAKE_SPLIT, cond: C_NEVER,      target: S_WAIT};
      S_A_HEAD:  w = '{op: OP_TAKE_HEAD,  cond: C_ALWAYS,     target: S_DONE};
      S_A_ADV:   w = '{op: OP_ADV,        cond: C_ALWAYS,     target: S_A_RD};
      S_A_FAIL:  w = '{op: OP_FAIL,       cond: C_NEVER,      target: S_WAIT};
      S_DONE:    w = '{op: OP_DONE,       cond: C_OUT_BUSY,   target: S_DONE};
      S_END:     w = '{op: OP_NOP,        cond: C_ALWAYS,     target: S_WAIT};
      S_R_CHK:   w = '{op: OP_NOP,        cond: C_BAD_REL,    target: S_DONE};
      S_R_RDP:   w = '{op: OP_RD_HP,      cond: C_NEVER,      target: S_WAIT};
      S_R_PLAT:  w = '{op: OP_P_LATCH,    cond: C_NO_NEXT,    target: S_R_WRP};
      S_R_RDN:   w = '{op: OP_RD_POS,     cond: C_NEVER,      target: S_WAIT};
      S_R_MRG:   w = '{op: OP_MERGE_N,    cond: C_NEVER,      target: S_WAIT};
      S_R_WRP:   w = '{op: OP_WR_P,       cond: C_NEVER,      target: S_WAIT};
      S_R_RDQ:   w = '{op: OP_RD_POS,     cond: C_NEVER,      target: S_WAIT};
      S_R_ZERO:  w = '{op: OP_NOP,        cond: C_LEN_ZERO,   target: S_DONE};
      S_R_HIT:   w = '{op: OP_NOP,        cond: C_ENDS_AT_HP, target: S_R_PREV};
      S_R_LAST:  w = '{op: OP_NOP,        cond: C_WALK_END,   target: S_DONE};
      S_R_ADV:   w = '{op: OP_ADV,        cond: C_ALWAYS,     target: S_R_RDQ};
      S_R_PREV:  w = '{op: OP_WR_PREV,    cond: C_ALWAYS,     target: S_DONE};
      default:   w = '{op: OP_NOP,        cond: C_ALWAYS,     target: S_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_pool(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (r > POOL_MAX) r = POOL_MAX;
    r = {r[LEN_W-1:2], 2'b00};
    if (r < POOL_MIN) r = POOL_MIN;
    return r;
  endfunction

  // Limit a merged length to the room left between pos and the pool end.
  function automatic logic [POS_W-1:0] sat_len(input logic [LEN_W-1:0] pool,
                                               input logic [POS_W-1:0] pos,
                                               input logic [POS_W-1:0] len);
    logic [POS_W-1:0] room;
    room = POS_W'(pool) - pos;
    return (len > room) ? room : len;
  endfunction

endpackage

// ===== rtl/ffba_hdr_ram.sv =====
module ffba_hdr_ram (
  input  logic              clk,
  input  ffba_pkg::ram_req_t req,
  output ffba_pkg::hdr_t    rdata
);

  ffba_pkg::hdr_t mem [ffba_pkg::WORDS];
  ffba_pkg::hdr_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ffba_seq.sv =====
module ffba_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  ffba_pkg::flags_t flags,
  output ffba_pkg::ctrl_t  ctrl
);

  logic [ffba_pkg::STEP_W-1:0] step_r;
  logic [ffba_pkg::STEP_W-1:0] step_nxt;
  logic                        take;

  assign ctrl = ffba_pkg::ucode(step_r);

  always_comb begin
    case (ctrl.cond)
      ffba_pkg::C_NEVER:      take = 1'b0;
      ffba_pkg::C_ALWAYS:     take = 1'b1;
      ffba_pkg::C_NOACC:      take = flags.noacc;
      ffba_pkg::C_REL:        take = flags.is_rel;
      ffba_pkg::C_REQ_BIG:    take = flags.req_big;
      ffba_pkg::C_POS_END:    take = flags.pos_end;
      ffba_pkg::C_LEN_ZERO:   take = flags.len_zero;
      ffba_pkg::C_NOFIT:      take = flags.nofit;
      ffba_pkg::C_OUT_BUSY:   take = flags.out_busy;
      ffba_pkg::C_BAD_REL:    take = flags.bad_rel;
      ffba_pkg::C_NO_NEXT:    take = flags.no_next;
      ffba_pkg::C_ENDS_AT_HP: take = flags.ends_at_hp;
      ffba_pkg::C_WALK_END:   take = flags.walk_end;
      default:                take = 1'b1;
    endcase
  end

  assign step_nxt = take ? ctrl.target : step_r + ffba_pkg::STEP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ffba_pkg::S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/ffba_dp.sv =====
module ffba_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ffba_pkg::LEN_W-1:0]          cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ffba_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ffba_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [0:0]                          out_tuser,
  input  ffba_pkg::op_e                       op,
  output ffba_pkg::flags_t                    flags,
  output ffba_pkg::ram_req_t                  ram_req,
  input  ffba_pkg::hdr_t                      ram_rdata
);

  localparam int LW = ffba_pkg::LEN_W;
  localparam int PW = ffba_pkg::POS_W;
  localparam int OW = ffba_pkg::OFF_W;
  localparam int AW = ffba_pkg::ADDR_W;
  localparam int PAD_W = ffba_pkg::OUT_TDATA_W - LW - OW;

  logic [LW-1:0] pool_r, pool_nxt;
  logic [LW-1:0] ftot_r, ftot_nxt;
  logic          init_pend_r, init_pend_nxt;
  logic          func_r, func_nxt;
  logic [LW-1:0] req_r, req_nxt;
  logic [OW-1:0] rel_r, rel_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] nsize_r, nsize_nxt;
  logic [OW-1:0] hp_r, hp_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic          granted_r, granted_nxt;
  logic [OW-1:0] offset_r, offset_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_granted_r, out_granted_nxt;
  logic [OW-1:0] out_offset_r, out_offset_nxt;
  logic [LW-1:0] out_free_r, out_free_nxt;

  logic          accept;
  logic          out_busy;
  logic [PW-1:0] rd_len;
  logic [PW-1:0] pool_w;
  logic [PW-1:0] hp_w;
  logic [PW-1:0] pos_plus_len;
  logic [PW-1:0] hp_plus_len;
  logic [PW-1:0] split_pos;
  logic          split;
  logic [PW-1:0] req_rnd;
  logic [OW-1:0] rel_off;
  logic [PW-1:0] fsum;

  assign in_tready = (op == ffba_pkg::OP_WAIT) && !init_pend_r;
  assign accept    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  assign rd_len       = PW'(ram_rdata.len);
  assign pool_w       = PW'(pool_r);
  assign hp_w         = PW'(hp_r);
  assign pos_plus_len = pos_r + rd_len;
  assign hp_plus_len  = hp_w + rd_len;
  assign split_pos    = pos_r + nsize_r;
  assign split        = (rd_len > nsize_r) && (split_pos < pool_w);
  assign req_rnd      = PW'(req_r) + PW'(3);
  assign rel_off      = {rel_r[OW-1:2], 2'b00};
  assign fsum         = PW'(ftot_r) + rd_len;

  always_comb begin
    flags.noacc      = !accept;
    flags.is_rel     = func_r;
    flags.req_big    = req_r > pool_r;
    flags.pos_end    = pos_r >= pool_w;
    flags.len_zero   = ram_rdata.len == '0;
    flags.nofit      = ram_rdata.used || (rd_len < nsize_r);
    flags.out_busy   = out_busy;
    flags.bad_rel    = (rel_r[OW-1:2] == '0) || (hp_w >= pool_w);
    flags.no_next    = (ram_rdata.len == '0) || (hp_plus_len >= pool_w);
    flags.ends_at_hp = pos_plus_len == hp_w;
    flags.walk_end   = pos_plus_len >= pool_w;
  end

  always_comb begin
    pool_nxt        = pool_r;
    ftot_nxt        = ftot_r;
    init_pend_nxt   = init_pend_r;
    func_nxt        = func_r;
    req_nxt         = req_r;
    rel_nxt         = rel_r;
    pos_nxt         = pos_r;
    nsize_nxt       = nsize_r;
    hp_nxt          = hp_r;
    plen_nxt        = plen_r;
    granted_nxt     = granted_r;
    offset_nxt      = offset_r;
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_offset_nxt  = out_offset_r;
    out_free_nxt    = out_free_r;
    ram_req         = '0;

    // Drop the word once the sink takes it.
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (op)
      ffba_pkg::OP_WAIT: begin
        if (init_pend_r) begin
          // Rebuild the pool as one free block at offset 0.
          ram_req.we         = 1'b1;
          ram_req.waddr      = '0;
          ram_req.wdata.used = 1'b0;
          ram_req.wdata.len  = pool_r;
          init_pend_nxt      = 1'b0;
        end else if (accept) begin
          func_nxt = in_tuser[0];
          req_nxt  = in_tdata[LW-1:0];
          rel_nxt  = in_tdata[LW+OW-1:LW];
        end
      end
      ffba_pkg::OP_LOAD: begin
        nsize_nxt   = {req_rnd[PW-1:2], 2'b00} + PW'(ffba_pkg::HDR_BYTES);
        hp_nxt      = rel_off - OW'(ffba_pkg::HDR_BYTES);
        pos_nxt     = '0;
        granted_nxt = 1'b1;
        offset_nxt  = '0;
      end
      ffba_pkg::OP_RD_POS: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = pos_r[AW+1:2];
      end
      ffba_pkg::OP_RD_HP: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = hp_w[AW+1:2];
      end
      ffba_pkg::OP_TAKE_SPLIT: begin
        if (split) begin
          ram_req.we         = 1'b1;
          ram_req.waddr      = split_pos[AW+1:2];
          ram_req.wdata.used = 1'b0;
          ram_req.wdata.len  = LW'(rd_len - nsize_r);
        end
        plen_nxt = split ? LW'(nsize_r) : ram_rdata.len;
      end
      ffba_pkg::OP_TAKE_HEAD: begin
        ram_req.we         = 1'b1;
        ram_req.waddr      = pos_r[AW+1:2];
        ram_req.wdata.used = 1'b1;
        ram_req.wdata.len  = plen_r;
        ftot_nxt           = (ftot_r > plen_r) ? ftot_r - plen_r : '0;
        offset_nxt         = OW'(pos_r + PW'(ffba_pkg::HDR_BYTES));
      end
      ffba_pkg::OP_ADV: begin
        pos_nxt = pos_plus_len;
      end
      ffba_pkg::OP_FAIL: begin
        granted_nxt = 1'b0;
        offset_nxt  = '0;
      end
      ffba_pkg::OP_DONE: begin
        if (!out_busy) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = granted_r;
          out_offset_nxt  = offset_r;
          out_free_nxt    = ftot_r;
        end
      end
      ffba_pkg::OP_P_LATCH: begin
        plen_nxt = ram_rdata.len;
        pos_nxt  = hp_plus_len;
        if (ram_rdata.used) begin
          ftot_nxt = (fsum > pool_w) ? pool_r : LW'(fsum);
        end
      end
      ffba_pkg::OP_MERGE_N: begin
        if (!ram_rdata.used) begin
          plen_nxt = LW'(ffba_pkg::sat_len(pool_r, hp_w, PW'(plen_r) + rd_len));
        end
      end
      ffba_pkg::OP_WR_P: begin
        ram_req.we         = 1'b1;
        ram_req.waddr      = hp_w[AW+1:2];
        ram_req.wdata.used = 1'b0;
        ram_req.wdata.len  = plen_r;
        pos_nxt            = '0;
      end
      ffba_pkg::OP_WR_PREV: begin
        if (!ram_rdata.used) begin
          ram_req.we         = 1'b1;
          ram_req.waddr      = pos_r[AW+1:2];
          ram_req.wdata.used = 1'b0;
          ram_req.wdata.len  = LW'(ffba_pkg::sat_len(pool_r, pos_r, rd_len + PW'(plen_r)));
        end
      end
      default: begin
      end
    endcase

    if (cfg_wr_en) begin
      pool_nxt      = ffba_pkg::clamp_pool(cfg_wr_data);
      ftot_nxt      = ffba_pkg::clamp_pool(cfg_wr_data);
      init_pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= ffba_pkg::POOL_RESET;
      ftot_r      <= ffba_pkg::POOL_RESET;
      init_pend_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      pool_r      <= pool_nxt;
      ftot_r      <= ftot_nxt;
      init_pend_r <= init_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    req_r         <= req_nxt;
    rel_r         <= rel_nxt;
    pos_r         <= pos_nxt;
    nsize_r       <= nsize_nxt;
    hp_r          <= hp_nxt;
    plen_r        <= plen_nxt;
    granted_r     <= granted_nxt;
    offset_r      <= offset_nxt;
    out_granted_r <= out_granted_nxt;
    out_offset_r  <= out_offset_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_free_r, out_offset_r};
  assign out_tuser  = out_granted_r;

endmodule

// ===== rtl/first_fit_block_allocator_unit.sv =====
// Allocate walks the block headers from offset 0 to the first fit; release walks
//   the headers from offset 0 to find the block before the released one.
// Requests are handled one at a time, paced by the header walk, one header-RAM read per step.
// Reset (rst_n low, synchronous): pool length back to its default, free total to the
//   pool length, output cleared; header 0 is rewritten in the first idle cycle.
// A configuration write also rewrites header 0 before the next request is accepted.
module first_fit_block_allocator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Pool length register.
  input  logic                             cfg_wr_en,
  input  logic [ffba_pkg::LEN_W-1:0]       cfg_wr_data,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ffba_pkg::IN_TDATA_W-1:0]  in_tdata,   // request_bytes[12:0], release_offset[24:13]
  input  logic [0:0]                       in_tuser,   // func (0 allocate, 1 release)
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,  // data_offset[11:0], free_bytes[24:12]
  output logic [0:0]                       out_tuser   // granted
);

  // Control word for the current step and the datapath conditions it may branch on.
  ffba_pkg::ctrl_t    ctrl;
  ffba_pkg::flags_t   flags;

  // Header RAM access and its registered read data.
  ffba_pkg::ram_req_t ram_req;
  ffba_pkg::hdr_t     ram_rdata;

  // Step counter and control store: walks the allocate or release program, jumping on
  // the condition its current word selects.
  ffba_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Datapath: walk pointer, block sizes, free total, pool length and the output word
  // register. It holds the finished word so the sink can stall without blocking the
  // next request from being taken.
  ffba_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .op          (ctrl.op),
    .flags       (flags),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  // One header per 4-byte word of the pool; only entries written since the last
  // rebuild are ever read by a walk from offset 0.
  ffba_hdr_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/ffba_checker.sv =====
`include "first_fit_block_allocator_unit_defines.svh"

module ffba_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wr_en,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                       out_tuser
);

  `FFBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result word dropped while stalled")
  `FFBA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")
  `FFBA_ASSERT_NOW(a_fail_offset, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[ffba_pkg::OFF_W-1:0] == '0, "failed allocate reports nonzero offset")
  `FFBA_ASSERT_NOW(a_free_bound, clk, rst_n, out_tvalid, out_tdata[ffba_pkg::OFF_W+ffba_pkg::LEN_W-1:ffba_pkg::OFF_W] <= ffba_pkg::POOL_MAX, "free total beyond pool size")
  `FFBA_ASSERT_NEXT(a_cfg_rebuild, clk, rst_n, cfg_wr_en, !in_tready, "request taken before pool rebuild")

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);

// ===== test/tb_first_fit_block_allocator_unit.sv =====
module tb_first_fit_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          POOL_BYTES  = ffba_pkg::POOL_BYTES;
  localparam int          WORDS       = ffba_pkg::WORDS;
  localparam int          LEN_W       = ffba_pkg::LEN_W;
  localparam int          OFF_W       = ffba_pkg::OFF_W;
  localparam int          IN_TDATA_W  = ffba_pkg::IN_TDATA_W;
  localparam int          OUT_TDATA_W = ffba_pkg::OUT_TDATA_W;

  localparam int unsigned HDR_SIZE    = 4;
  localparam int unsigned MIN_POOL    = 8;
  localparam int unsigned POOL_CEIL   = (POOL_BYTES / 4) * 4;
  localparam int          STALL_LIMIT = 20000;
  localparam int          PHASE_ITEMS = 85;
  localparam int          HOLD_CYCLES = 400;

  typedef enum bit {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_kind_e;

  typedef struct {
    req_kind_e        kind;
    logic [LEN_W-1:0] want_bytes;
    logic [OFF_W-1:0] rel_offset;
  } pool_req_t;

  typedef struct {
    logic             granted;
    logic [OFF_W-1:0] data_offset;
    logic [LEN_W-1:0] free_bytes;
  } reply_t;

  // Mirror of the header list plus the queue of replies still owed by the block.
  class pool_tracker;
    int unsigned pool;
    int unsigned free_total;
    bit          hdr_used[WORDS];
    int unsigned hdr_len[WORDS];
    bit          hdr_known[WORDS];
    bit          hit_unknown;
    int          errors;
    reply_t      expected_replies[$];

    function void set_pool(int unsigned v);
      v = v & 32'h1FFF;
      if (v > POOL_CEIL) v = POOL_CEIL;
      v = v & ~32'd3;
      if (v < MIN_POOL) v = MIN_POOL;
      pool = v;
      foreach (hdr_used[i]) begin
        hdr_used[i]  = 1'b0;
        hdr_len[i]   = 0;
        hdr_known[i] = 1'b0;
      end
      hdr_len[0]   = pool;
      hdr_known[0] = 1'b1;
      free_total   = pool;
    endfunction

    function int unsigned word_of(int unsigned pos);
      int unsigned w;
      w = pos >> 2;
      if (w >= WORDS) w = WORDS - 1;
      return w;
    endfunction

    // Flag any read of a header that was never written since the last pool setup.
    function int unsigned read_word(int unsigned pos);
      int unsigned w;
      w = word_of(pos);
      if (!hdr_known[w]) hit_unknown = 1'b1;
      return w;
    endfunction

    function int unsigned fit_len(int unsigned pos, int unsigned l);
      int unsigned room;
      room = pool - pos;
      return (l > room) ? room : l;
    endfunction

    function bit take_block(int unsigned want, output int unsigned where);
      int unsigned need, pos, w, r, blen;
      where = 0;
      if (want > pool) return 1'b0;
      need = ((want + 3) & ~32'd3) + HDR_SIZE;
      pos = 0;
      while (pos < pool) begin
        w = read_word(pos);
        blen = hdr_len[w];
        if (blen == 0) return 1'b0;
        if (!hdr_used[w] && blen >= need) begin
          hdr_used[w] = 1'b1;
          // split the tail off as a new free block when it fits inside the pool
          if (blen > need && pos + need < pool) begin
            r = word_of(pos + need);
            hdr_used[r]  = 1'b0;
            hdr_len[r]   = blen - need;
            hdr_known[r] = 1'b1;
            hdr_len[w]   = need;
          end
          free_total = (free_total > hdr_len[w]) ? free_total - hdr_len[w] : 0;
          where = pos + HDR_SIZE;
          return 1'b1;
        end
        pos += blen;
      end
      return 1'b0;
    endfunction

    function void give_back(int unsigned off);
      int unsigned hp, p, q, n, c, ql;
      off = off & ~32'd3;
      if (off < HDR_SIZE) return;
      hp = off - HDR_SIZE;
      if (hp >= pool) return;
      p = read_word(hp);
      if (hdr_used[p]) begin
        free_total += hdr_len[p];
        if (free_total > pool) free_total = pool;
      end
      hdr_used[p] = 1'b0;
      q = hp + hdr_len[p];
      if (hdr_len[p] != 0 && q < pool) begin
        n = read_word(q);
        if (!hdr_used[n]) hdr_len[p] = fit_len(hp, hdr_len[p] + hdr_len[n]);
      end
      // walk from the start for the block that ends right at this header
      q = 0;
      while (q < pool) begin
        c = read_word(q);
        ql = hdr_len[c];
        if (ql == 0) return;
        if (q + ql == hp) begin
          if (!hdr_used[c]) hdr_len[c] = fit_len(q, ql + hdr_len[p]);
          return;
        end
        if (q + ql >= pool) return;
        q += ql;
      end
    endfunction

    function reply_t predict_reply(pool_req_t rq);
      reply_t      rp;
      int unsigned where;
      bit          ok;
      where = 0;
      ok    = 1'b1;
      if (rq.kind == REQ_ALLOC) begin
        ok = take_block(int'(rq.want_bytes), where);
        if (!ok) where = 0;
      end else begin
        give_back(int'(rq.rel_offset));
      end
      rp.granted     = ok;
      rp.data_offset = where[OFF_W-1:0];
      rp.free_bytes  = free_total[LEN_W-1:0];
      return rp;
    endfunction

    // Dry run on a saved copy: true when the request reads only written headers.
    function bit stays_defined(pool_req_t rq);
      bit          used_s[WORDS];
      int unsigned len_s[WORDS];
      bit          known_s[WORDS];
      int unsigned free_s;
      used_s  = hdr_used;
      len_s   = hdr_len;
      known_s = hdr_known;
      free_s  = free_total;
      hit_unknown = 1'b0;
      void'(predict_reply(rq));
      hdr_used   = used_s;
      hdr_len    = len_s;
      hdr_known  = known_s;
      free_total = free_s;
      return !hit_unknown;
    endfunction

    function reply_t note_request(pool_req_t rq);
      reply_t rp;
      rp = predict_reply(rq);
      expected_replies.push_back(rp);
      return rp;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("ERROR: %s", what);
    endtask

    task check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected word granted=%b offset=%0d free=%0d",
                                  got.granted, got.data_offset, got.free_bytes));
        return;
      end
      want = expected_replies.pop_front();
      if (got.granted !== want.granted)
        report_mismatch($sformatf("granted got %b want %b", got.granted, want.granted));
      if (got.data_offset !== want.data_offset)
        report_mismatch($sformatf("data_offset got %0d want %0d",
                                  got.data_offset, want.data_offset));
      if (got.free_bytes !== want.free_bytes)
        report_mismatch($sformatf("free_bytes got %0d want %0d",
                                  got.free_bytes, want.free_bytes));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [LEN_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // request_bytes[12:0], release_offset[24:13]
  logic [0:0]             in_tuser;   // func (0 allocate, 1 release)
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // data_offset[11:0], free_bytes[24:12]
  logic [0:0]             out_tuser;  // granted

  pool_tracker tracker;
  int          live_offsets[$];   // data offsets handed out and not yet given back
  int          replies_seen;
  int          quiet_cycles;

  first_fit_block_allocator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function int pick_burst();
    if ($urandom_range(0, 99) < 70) return $urandom_range(1, 8);
    return $urandom_range(20, 120);
  endfunction

  // Offer one request word, hold it until taken, then log the predicted reply.
  task automatic send_request(input pool_req_t rq);
    reply_t rp;
    in_tuser  <= rq.kind;
    in_tdata  <= {{(IN_TDATA_W - LEN_W - OFF_W){1'b0}}, rq.rel_offset, rq.want_bytes};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    rp = tracker.note_request(rq);
    // a grant at the very top of the pool wraps to zero and cannot be given back
    if (rq.kind == REQ_ALLOC && rp.granted && rp.data_offset != 0)
      live_offsets.push_back(int'(rp.data_offset));
  endtask

  task automatic pause_sender(input bit steady);
    int g;
    if (steady) return;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic issue(input req_kind_e kind, input int want, input int off);
    pool_req_t rq;
    rq.kind       = kind;
    rq.want_bytes = LEN_W'(want);
    rq.rel_offset = OFF_W'(off);
    send_request(rq);
    pause_sender(1'b0);
  endtask

  // Drain all owed replies, let the block settle, then write the pool length.
  task automatic reconfigure(input int v);
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LEN_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_pool(v);
    live_offsets.delete();
  endtask

  // Mostly well-formed allocate/release traffic, with oversized and stray requests.
  task automatic choose_request(output pool_req_t rq);
    int          roll;
    int          idx;
    int unsigned p;
    p = tracker.pool;
    roll = $urandom_range(0, 99);
    rq.kind       = REQ_ALLOC;
    rq.want_bytes = LEN_W'($urandom);
    rq.rel_offset = OFF_W'($urandom);
    if (roll < 40 && live_offsets.size() > 0) begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      rq.kind       = REQ_RELEASE;
      rq.rel_offset = OFF_W'(live_offsets[idx]) | OFF_W'($urandom_range(0, 3));
      live_offsets.delete(idx);
    end else if (roll < 55) begin
      rq.kind = REQ_RELEASE;
      if ($urandom_range(0, 1) == 0) rq.rel_offset = OFF_W'($urandom_range(0, p + 8));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      rq.want_bytes = LEN_W'($urandom_range(0, (p >> 4) + 4));
      else if (roll < 92) rq.want_bytes = LEN_W'($urandom_range(0, p));
      else                rq.want_bytes = LEN_W'($urandom_range(p + 1, 8191));
    end
    // swap anything that would touch an unwritten header for a harmless release
    if (!tracker.stays_defined(rq)) begin
      rq.kind       = REQ_RELEASE;
      rq.rel_offset = OFF_W'($urandom_range(0, 3));
    end
  endtask

  initial begin : stimulus
    pool_req_t rq;
    int        plan[$];
    bit        steady;
    tracker = new();
    tracker.set_pool(POOL_BYTES);
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Full pool after reset: walk to the top word and wrap the offset.
    issue(REQ_ALLOC, 0, 0);        // header-only block at the bottom
    issue(REQ_ALLOC, 8191, 4095);  // oversized, all request bits set
    issue(REQ_ALLOC, 4096, 0);     // equal to pool but no room for the header
    issue(REQ_ALLOC, 4080, 0);     // leaves one 8-byte block at the top
    issue(REQ_ALLOC, 0, 0);        // split the top block, last word stays free
    issue(REQ_ALLOC, 0, 0);        // last word taken, offset 4096 wraps to zero
    issue(REQ_ALLOC, 1, 0);        // walk runs off the end and fails
    issue(REQ_RELEASE, 0, 3);      // offset below the first data word
    issue(REQ_RELEASE, 0, 4);      // frees the bottom block
    issue(REQ_RELEASE, 0, 8);      // merges into the free block before it
    issue(REQ_RELEASE, 8191, 8);   // release of a block already free

    // Smallest pool.
    reconfigure(8);
    issue(REQ_ALLOC, 9, 0);        // larger than the pool
    issue(REQ_ALLOC, 8, 0);        // fits the pool but not with a header
    issue(REQ_ALLOC, 4, 0);        // takes the whole pool
    issue(REQ_ALLOC, 0, 0);        // nothing left
    issue(REQ_RELEASE, 0, 4095);   // header beyond the pool end
    issue(REQ_RELEASE, 0, 4);
    issue(REQ_RELEASE, 0, 4);

    plan = '{4096, 64, 8191, 13, 0, 1000, 4095, 8,
             $urandom_range(0, 8191), $urandom_range(0, 8191)};
    foreach (plan[i]) begin
      reconfigure(plan[i]);
      steady = ($urandom_range(0, 2) == 0);
      repeat (PHASE_ITEMS) begin
        choose_request(rq);
        send_request(rq);
        pause_sender(steady);
      end
    end

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (tracker.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random ready pattern plus one long hold-off so the input backs up.
  initial begin : sink
    bit held;
    int g;
    held = 1'b0;
    out_tready <= 1'b0;
    repeat (5) @(posedge clk);
    forever begin
      if (!held && replies_seen >= 60) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat (pick_burst()) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // Compare each taken result word, and stop if nothing moves for too long.
  always @(posedge clk) begin
    reply_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.granted     = out_tuser[0];
        got.data_offset = out_tdata[OFF_W-1:0];
        got.free_bytes  = out_tdata[OFF_W+LEN_W-1:OFF_W];
        tracker.check_reply(got);
        replies_seen++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_hdr_ram.sv
rtl/ffba_seq.sv
rtl/ffba_dp.sv
rtl/first_fit_block_allocator_unit.sv
rtl/ffba_checker.sv
test/tb_first_fit_block_allocator_unit.sv
